>>> src/hsfd_pkg.sv
package hsfd_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [2:0]  CRC_SPAN      = 3'd6;
    localparam logic [2:0]  POS_CRC_LOW   = 3'd6;
    localparam logic [2:0]  POS_CRC_HIGH  = 3'd7;
    localparam logic [2:0]  POS_PAYLOAD   = 3'd2;
    localparam logic [7:0]  MAG_MASK      = 8'h7F;
    localparam logic [7:0]  SIGN_BIT      = 8'h80;
    localparam logic [15:0] READING_RESET = 16'd990;

    typedef logic [15:0] crc_t;

endpackage

>>> src/hsfd_crc_byte.sv
module hsfd_crc_byte
    import hsfd_pkg::*;
(
    input  crc_t       crc_in,
    input  logic [7:0] data,
    output crc_t       crc_out
);

    // eight shift/xor steps of the reflected polynomial, lsb first
    always_comb
    begin
        crc_t c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

>>> src/humidity_sensor_frame_decoder_top.sv
// sensor reply frame decoder
//
// input stream: one reply byte per request on s_axis_tdata; s_axis_tuser
// marks byte 0 of a frame and restarts the byte count and the crc
// output stream: one request per 8-byte frame, issued on byte 7; tuser holds
// crc_ok, tdata holds the held humidity (low half) and the held temperature
// (high half), both in tenths
//
// a taken byte is held in the input register and decoded from there into the state
// registers; on byte 7 the decode also loads the result register that drives the request
// throughput: one byte per cycle unless a result stall holds a byte, set by the
// combinational unrolled crc byte update between the input and state/result registers
//
// stall: the result register holds its request until taken; a decode that
// would produce a result waits in the input register while the result
// register is full and not being drained, and s_axis_tready drops meanwhile
// bytes that produce no result never wait on the output side
//
// reset: byte count 0, crc 0xffff, held readings 99.0, both channels empty
module humidity_sensor_frame_decoder_top
    import hsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
    output logic        m_axis_tuser    // [0] crc_ok
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // frame state
    logic [2:0] byte_count_reg;
    crc_t       crc_reg;
    logic [7:0] payload_reg [4];
    logic [7:0] crc_low_reg;
    logic [15:0] hum_reg;
    logic [15:0] temp_reg;

    // result register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;

    // decode of the byte in the input register
    logic [2:0]  pos;
    crc_t        crc_base;
    crc_t        crc_new;
    logic        is_last;
    logic        crc_match;
    logic        out_free;
    logic        advance;
    logic [14:0] mag;
    logic [15:0] hum_next;
    logic [15:0] temp_next;

    hsfd_crc_byte u_crc
    (
        .crc_in  (crc_base),
        .data    (in_byte_reg),
        .crc_out (crc_new)
    );

    always_comb
    begin
        pos       = in_start_reg ? 3'd0 : byte_count_reg;
        crc_base  = in_start_reg ? CRC_INIT : crc_reg;
        is_last   = (pos == POS_CRC_HIGH);
        crc_match = ({in_byte_reg, crc_low_reg} == crc_base);
        out_free  = !m_valid_reg || m_axis_tready;
        advance   = in_valid_reg && (!is_last || out_free);

        // sign-magnitude temperature, negative zero folds to zero
        mag = {payload_reg[2][6:0] & MAG_MASK[6:0], payload_reg[3]};
        if (crc_match)
        begin
            hum_next = {payload_reg[0], payload_reg[1]};
            if ((payload_reg[2] & SIGN_BIT) != 8'h00)
            begin
                temp_next = 16'h0000 - {1'b0, mag};
            end
            else
            begin
                temp_next = {1'b0, mag};
            end
        end
        else
        begin
            hum_next  = hum_reg;
            temp_next = temp_reg;
        end
    end

    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // frame state: count, crc and held readings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 3'd0;
            crc_reg        <= CRC_INIT;
            hum_reg        <= READING_RESET;
            temp_reg       <= READING_RESET;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                byte_count_reg <= 3'd0;
                crc_reg        <= CRC_INIT;
                hum_reg        <= hum_next;
                temp_reg       <= temp_next;
            end
            else
            begin
                byte_count_reg <= pos + 3'd1;
                if (pos < CRC_SPAN)
                begin
                    crc_reg <= crc_new;
                end
                else
                begin
                    crc_reg <= crc_base;
                end
            end
        end
    end

    // captured payload and low crc byte
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pos >= POS_PAYLOAD && pos < CRC_SPAN)
            begin
                payload_reg[2'(pos - POS_PAYLOAD)] <= in_byte_reg;
            end
            if (pos == POS_CRC_LOW)
            begin
                crc_low_reg <= in_byte_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance && is_last)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            m_data_reg <= {temp_next, hum_next};
            m_user_reg <= crc_match;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // frame end restarts count and crc
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (byte_count_reg == 3'd0 && crc_reg == CRC_INIT))
        else $error("frame end did not restart count and crc");

    // held readings move only on a frame with a good crc
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && is_last && crc_match) |=> ($stable(hum_reg) && $stable(temp_reg)))
        else $error("held readings changed without a good frame");

    // a new result comes only from a decoded last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(advance && is_last))
        else $error("result issued without a last byte");

    // a waiting byte is neither lost nor overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_start_reg)))
        else $error("stalled byte lost");

    // a pending result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |-> !(advance && is_last))
        else $error("result overwritten while stalled");

endmodule
